@@ hw/rtl/brs_pkg.sv @@
// Package: shared step codes and control structs for the breaker relay sequencer.
`default_nettype none

package brs_pkg;

   // Sequencer step, one-hot
   typedef enum logic [6:0] {
      STEP_ON   = 7'b0000001,
      STEP_OFF  = 7'b0000010,
      STEP_ON1  = 7'b0000100,
      STEP_ON2  = 7'b0001000,
      STEP_OFF1 = 7'b0010000,
      STEP_OFF2 = 7'b0100000,
      STEP_DONE = 7'b1000000
   } step_type;

   // func field codes
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_CMD  = 1'b1;

   // Command word bit positions
   localparam int CMD_MOP_CLOSE = 0;
   localparam int CMD_MOP_OPEN  = 1;
   localparam int CMD_VCB_CLOSE = 2;
   localparam int CMD_VCB_OPEN  = 3;
   localparam int CMD_PRE_ON    = 4;
   localparam int CMD_PRE_OFF   = 5;
   localparam int CMD_DC_MAIN   = 6;
   localparam int CMD_DC_PAIR   = 7;
   localparam int CMD_USED_BITS = 8;

   localparam int CMD_WIDTH     = 16;
   localparam int PRE_RELAYS    = 3;

   // Per-item control into a breaker sequencer
   typedef struct packed {
      logic is_cmd;
      logic close_req;
      logic open_req;
      logic feedback;
   } brk_ctl_type;

   // Breaker coil drives
   typedef struct packed {
      logic close_coil;
      logic open_coil;
   } coil_type;

   // Per-item control into the pre-charge sequencer
   typedef struct packed {
      logic is_cmd;
      logic on_req;
      logic off_req;
   } pre_ctl_type;

endpackage

`default_nettype wire

@@ hw/rtl/brs_req_if.sv @@
// Interface: input item channel of the breaker relay sequencer.
`default_nettype none

interface brs_req_if;
   import brs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 func;
   logic [CMD_WIDTH-1:0] command_map;
   logic                 mop_feedback;
   logic                 vcb_feedback;

   modport source (
      output valid, func, command_map, mop_feedback, vcb_feedback,
      input  ready
   );

   modport sink (
      input  valid, func, command_map, mop_feedback, vcb_feedback,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/brs_rsp_if.sv @@
// Interface: result item channel of the breaker relay sequencer.
`default_nettype none

interface brs_rsp_if;
   import brs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  mop_close_coil;
   logic                  mop_open_coil;
   logic                  vcb_close_coil;
   logic                  vcb_open_coil;
   logic [PRE_RELAYS-1:0] precharge_relays;
   logic                  dc_main_relay;
   logic                  dc_pair_relays;
   logic                  mop_busy;
   logic                  vcb_busy;
   logic                  precharge_busy;

   modport source (
      output valid, mop_close_coil, mop_open_coil, vcb_close_coil, vcb_open_coil,
             precharge_relays, dc_main_relay, dc_pair_relays,
             mop_busy, vcb_busy, precharge_busy,
      input  ready
   );

   modport sink (
      input  valid, mop_close_coil, mop_open_coil, vcb_close_coil, vcb_open_coil,
             precharge_relays, dc_main_relay, dc_pair_relays,
             mop_busy, vcb_busy, precharge_busy,
      output ready
   );
endinterface

`default_nettype wire

@@ hw/rtl/brs_breaker_step.sv @@
// Next-step and coil logic for one breaker sequencer.
`default_nettype none

module brs_breaker_step
   import brs_pkg::*;
(
   input  wire step_type    step,
   input  wire coil_type    coils,
   input  wire brk_ctl_type ctl,
   output step_type         step_next,
   output coil_type         coils_next
);

   always_comb begin
      step_next  = step;
      coils_next = coils;
      if (ctl.is_cmd) begin
         // close needs feedback on, open needs it off; close checked first
         if (step == STEP_DONE) begin
            if (ctl.close_req && ctl.feedback) begin
               step_next = STEP_ON;
            end else if (ctl.open_req && !ctl.feedback) begin
               step_next = STEP_OFF;
            end
         end
      end else begin
         unique case (step)
            STEP_ON: begin
               coils_next = '0;
               step_next  = STEP_ON1;
            end
            STEP_OFF: begin
               coils_next = '0;
               step_next  = STEP_OFF1;
            end
            STEP_ON1: begin
               coils_next.close_coil = 1'b1;
               step_next             = STEP_ON2;
            end
            STEP_ON2: begin
               coils_next.close_coil = 1'b0;
               step_next             = STEP_DONE;
            end
            STEP_OFF1: begin
               coils_next.open_coil = 1'b1;
               step_next            = STEP_OFF2;
            end
            STEP_OFF2: begin
               coils_next.open_coil = 1'b0;
               step_next            = STEP_DONE;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/brs_precharge_step.sv @@
// Next-step and relay logic for the pre-charge sequencer.
`default_nettype none

module brs_precharge_step
   import brs_pkg::*;
(
   input  wire step_type              step,
   input  wire logic [PRE_RELAYS-1:0] relays,
   input  wire pre_ctl_type           ctl,
   output step_type                   step_next,
   output logic [PRE_RELAYS-1:0]      relays_next
);

   always_comb begin
      step_next   = step;
      relays_next = relays;
      if (ctl.is_cmd) begin
         if (step == STEP_DONE) begin
            if (ctl.on_req) begin
               step_next = STEP_ON;
            end else if (ctl.off_req) begin
               step_next = STEP_OFF;
            end
         end
      end else begin
         unique case (step)
            STEP_ON:   step_next = STEP_ON1;
            STEP_OFF:  step_next = STEP_OFF1;
            STEP_ON1: begin
               // all three relays close together
               relays_next = '1;
               step_next   = STEP_DONE;
            end
            STEP_OFF1: begin
               relays_next = '0;
               step_next   = STEP_DONE;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/breaker_relay_sequencer.sv @@
// Top level: input register, three relay sequencers and the result stage.
// Accepted items wait in the input register until the result slot is free. Throughput:
// one item per cycle while results are taken; the input register refills in the same
// cycle it hands its item on, and the state/result registers load whenever the result
// slot frees. Reset (synchronous): all steps to done, all relays off, both stages empty.
// The result fields are the state registers themselves, held until taken.
`default_nettype none

module breaker_relay_sequencer
   import brs_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   brs_req_if.sink    req_ch,
   brs_rsp_if.source  rsp_ch
);

   // Input register
   logic                     in_valid_ff, in_valid_in;
   logic                     in_func_ff;
   logic [CMD_USED_BITS-1:0] in_cmd_ff;
   logic                     in_mop_fb_ff;
   logic                     in_vcb_fb_ff;

   // Sequencer state, doubles as the result register
   step_type              mop_step_ff, mop_step_in;
   step_type              vcb_step_ff, vcb_step_in;
   step_type              pre_step_ff, pre_step_in;
   coil_type              mop_coils_ff, mop_coils_in;
   coil_type              vcb_coils_ff, vcb_coils_in;
   logic [PRE_RELAYS-1:0] pre_relays_ff, pre_relays_in;
   logic                  dc_main_ff, dc_main_in;
   logic                  dc_pair_ff, dc_pair_in;
   logic                  out_valid_ff, out_valid_in;

   logic        advance;
   logic        take_in;
   logic        is_cmd;
   brk_ctl_type mop_ctl;
   brk_ctl_type vcb_ctl;
   pre_ctl_type pre_ctl;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign take_in = req_ch.valid && req_ch.ready;
   assign is_cmd = (in_func_ff == FUNC_CMD);

   assign mop_ctl = '{is_cmd:    is_cmd,
                      close_req: in_cmd_ff[CMD_MOP_CLOSE],
                      open_req:  in_cmd_ff[CMD_MOP_OPEN],
                      feedback:  in_mop_fb_ff};
   assign vcb_ctl = '{is_cmd:    is_cmd,
                      close_req: in_cmd_ff[CMD_VCB_CLOSE],
                      open_req:  in_cmd_ff[CMD_VCB_OPEN],
                      feedback:  in_vcb_fb_ff};
   assign pre_ctl = '{is_cmd:  is_cmd,
                      on_req:  in_cmd_ff[CMD_PRE_ON],
                      off_req: in_cmd_ff[CMD_PRE_OFF]};

   brs_breaker_step u_mop (
      .step       (mop_step_ff),
      .coils      (mop_coils_ff),
      .ctl        (mop_ctl),
      .step_next  (mop_step_in),
      .coils_next (mop_coils_in)
   );

   brs_breaker_step u_vcb (
      .step       (vcb_step_ff),
      .coils      (vcb_coils_ff),
      .ctl        (vcb_ctl),
      .step_next  (vcb_step_in),
      .coils_next (vcb_coils_in)
   );

   brs_precharge_step u_pre (
      .step        (pre_step_ff),
      .relays      (pre_relays_ff),
      .ctl         (pre_ctl),
      .step_next   (pre_step_in),
      .relays_next (pre_relays_in)
   );

   // DC relays follow the command word directly; ticks leave them alone
   assign dc_main_in = is_cmd ? in_cmd_ff[CMD_DC_MAIN] : dc_main_ff;
   assign dc_pair_in = is_cmd ? in_cmd_ff[CMD_DC_PAIR] : dc_pair_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_in) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         mop_step_ff   <= STEP_DONE;
         vcb_step_ff   <= STEP_DONE;
         pre_step_ff   <= STEP_DONE;
         mop_coils_ff  <= '0;
         vcb_coils_ff  <= '0;
         pre_relays_ff <= '0;
         dc_main_ff    <= 1'b0;
         dc_pair_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mop_step_ff   <= mop_step_in;
            vcb_step_ff   <= vcb_step_in;
            pre_step_ff   <= pre_step_in;
            mop_coils_ff  <= mop_coils_in;
            vcb_coils_ff  <= vcb_coils_in;
            pre_relays_ff <= pre_relays_in;
            dc_main_ff    <= dc_main_in;
            dc_pair_ff    <= dc_pair_in;
         end
      end
   end

   // Item payload, no reset needed
   always_ff @(posedge clock) begin
      if (take_in) begin
         in_func_ff   <= req_ch.func;
         in_cmd_ff    <= req_ch.command_map[CMD_USED_BITS-1:0];
         in_mop_fb_ff <= req_ch.mop_feedback;
         in_vcb_fb_ff <= req_ch.vcb_feedback;
      end
   end

   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.mop_close_coil   = mop_coils_ff.close_coil;
   assign rsp_ch.mop_open_coil    = mop_coils_ff.open_coil;
   assign rsp_ch.vcb_close_coil   = vcb_coils_ff.close_coil;
   assign rsp_ch.vcb_open_coil    = vcb_coils_ff.open_coil;
   assign rsp_ch.precharge_relays = pre_relays_ff;
   assign rsp_ch.dc_main_relay    = dc_main_ff;
   assign rsp_ch.dc_pair_relays   = dc_pair_ff;
   assign rsp_ch.mop_busy         = (mop_step_ff != STEP_DONE);
   assign rsp_ch.vcb_busy         = (vcb_step_ff != STEP_DONE);
   assign rsp_ch.precharge_busy   = (pre_step_ff != STEP_DONE);

endmodule

`default_nettype wire

@@ sim/breaker_relay_sequencer_test.sv @@
// Testbench for breaker_relay_sequencer: bursty command/tick driver, stalling sink, scoreboard.
module breaker_relay_sequencer_test;
   import brs_pkg::*;

   typedef struct {
      logic                 func;
      logic [CMD_WIDTH-1:0] command_map;
      logic                 mop_feedback;
      logic                 vcb_feedback;
   } relay_request_type;

   typedef struct {
      logic                  mop_close_coil;
      logic                  mop_open_coil;
      logic                  vcb_close_coil;
      logic                  vcb_open_coil;
      logic [PRE_RELAYS-1:0] precharge_relays;
      logic                  dc_main_relay;
      logic                  dc_pair_relays;
      logic                  mop_busy;
      logic                  vcb_busy;
      logic                  precharge_busy;
   } relay_status_type;

   logic clock;
   logic reset;

   brs_req_if req_ch ();
   brs_rsp_if rsp_ch ();

   breaker_relay_sequencer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   relay_request_type pending_requests[$];
   relay_status_type  expected_status[$];
   relay_request_type next_request;
   relay_request_type seen_request;
   relay_status_type  want_status;

   // shadow copy of the sequencers
   step_type              mop_seq, vcb_seq, pre_seq;
   logic                  mop_close, mop_open, vcb_close, vcb_open;
   logic [PRE_RELAYS-1:0] pre_relays;
   logic                  dc_main, dc_pair;

   int mismatch_count = 0;
   int status_checked = 0;
   int tick_count     = 0;
   int command_count  = 0;
   int triggers_taken = 0;
   int burst_left;
   int gap_left;
   int sink_cycle     = 0;
   int sink_mode      = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic void add_item(logic f, logic [CMD_WIDTH-1:0] c, logic m, logic v);
      relay_request_type r;
      r.func         = f;
      r.command_map  = c;
      r.mop_feedback = m;
      r.vcb_feedback = v;
      pending_requests.push_back(r);
   endfunction

   function automatic void advance_breaker(inout step_type st, inout logic close_c,
                                           inout logic open_c);
      case (st)
         STEP_ON: begin
            close_c = 1'b0;
            open_c  = 1'b0;
            st      = STEP_ON1;
         end
         STEP_OFF: begin
            close_c = 1'b0;
            open_c  = 1'b0;
            st      = STEP_OFF1;
         end
         STEP_ON1: begin
            close_c = 1'b1;
            st      = STEP_ON2;
         end
         STEP_ON2: begin
            close_c = 1'b0;
            st      = STEP_DONE;
         end
         STEP_OFF1: begin
            open_c = 1'b1;
            st     = STEP_OFF2;
         end
         STEP_OFF2: begin
            open_c = 1'b0;
            st     = STEP_DONE;
         end
         default: ;
      endcase
   endfunction

   function automatic relay_status_type next_relay_status(relay_request_type r);
      relay_status_type s;
      if (r.func == FUNC_CMD) begin
         command_count++;
         // triggers only land on an idle sequencer; lower bit of a pair wins
         if (r.command_map[CMD_MOP_CLOSE] && mop_seq == STEP_DONE && r.mop_feedback) begin
            mop_seq = STEP_ON;
            triggers_taken++;
         end
         if (r.command_map[CMD_MOP_OPEN] && mop_seq == STEP_DONE && !r.mop_feedback) begin
            mop_seq = STEP_OFF;
            triggers_taken++;
         end
         if (r.command_map[CMD_VCB_CLOSE] && vcb_seq == STEP_DONE && r.vcb_feedback) begin
            vcb_seq = STEP_ON;
            triggers_taken++;
         end
         if (r.command_map[CMD_VCB_OPEN] && vcb_seq == STEP_DONE && !r.vcb_feedback) begin
            vcb_seq = STEP_OFF;
            triggers_taken++;
         end
         if (r.command_map[CMD_PRE_ON] && pre_seq == STEP_DONE) begin
            pre_seq = STEP_ON;
            triggers_taken++;
         end
         if (r.command_map[CMD_PRE_OFF] && pre_seq == STEP_DONE) begin
            pre_seq = STEP_OFF;
            triggers_taken++;
         end
         dc_main = r.command_map[CMD_DC_MAIN];
         dc_pair = r.command_map[CMD_DC_PAIR];
      end else begin
         tick_count++;
         case (pre_seq)
            STEP_ON:  pre_seq = STEP_ON1;
            STEP_OFF: pre_seq = STEP_OFF1;
            STEP_ON1: begin
               pre_relays = '1;
               pre_seq    = STEP_DONE;
            end
            STEP_OFF1: begin
               pre_relays = '0;
               pre_seq    = STEP_DONE;
            end
            default: ;
         endcase
         advance_breaker(mop_seq, mop_close, mop_open);
         advance_breaker(vcb_seq, vcb_close, vcb_open);
      end
      s.mop_close_coil   = mop_close;
      s.mop_open_coil    = mop_open;
      s.vcb_close_coil   = vcb_close;
      s.vcb_open_coil    = vcb_open;
      s.precharge_relays = pre_relays;
      s.dc_main_relay    = dc_main;
      s.dc_pair_relays   = dc_pair;
      s.mop_busy         = (mop_seq != STEP_DONE);
      s.vcb_busy         = (vcb_seq != STEP_DONE);
      s.precharge_busy   = (pre_seq != STEP_DONE);
      return s;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      if (mismatch_count <= 30)
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic compare_field(string what, logic [PRE_RELAYS-1:0] got,
                                logic [PRE_RELAYS-1:0] want);
      if (got !== want) report_mismatch(what, int'(got), int'(want));
   endtask

   // driver: bursts of items with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left   <= 8;
         gap_left     <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left != 0 || pending_requests.size() == 0) begin
            req_ch.valid <= 1'b0;
            if (gap_left != 0) gap_left <= gap_left - 1;
         end else begin
            next_request = pending_requests.pop_front();
            req_ch.func         <= next_request.func;
            req_ch.command_map  <= next_request.command_map;
            req_ch.mop_feedback <= next_request.mop_feedback;
            req_ch.vcb_feedback <= next_request.vcb_feedback;
            req_ch.valid        <= 1'b1;
            if (burst_left <= 1) begin
               if ($urandom_range(0, 7) == 0) begin
                  burst_left <= 150;
                  gap_left   <= 0;
               end else begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= $urandom_range(0, 6);
               end
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // sink: a randomly redrawn stall mode drives ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_cycle   <= 0;
         sink_mode    <= 0;
      end else begin
         sink_cycle <= sink_cycle + 1;
         if (sink_cycle % 256 == 255) sink_mode <= $urandom_range(0, 3);
         case (sink_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= (sink_cycle % 7 > 2);
         endcase
      end
   end

   // monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      if (reset) begin
         mop_seq    = STEP_DONE;
         vcb_seq    = STEP_DONE;
         pre_seq    = STEP_DONE;
         mop_close  = 1'b0;
         mop_open   = 1'b0;
         vcb_close  = 1'b0;
         vcb_open   = 1'b0;
         pre_relays = '0;
         dc_main    = 1'b0;
         dc_pair    = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            seen_request.func         = req_ch.func;
            seen_request.command_map  = req_ch.command_map;
            seen_request.mop_feedback = req_ch.mop_feedback;
            seen_request.vcb_feedback = req_ch.vcb_feedback;
            expected_status.push_back(next_relay_status(seen_request));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_status.size() == 0) begin
               report_mismatch("unexpected result item", 1, 0);
            end else begin
               want_status = expected_status.pop_front();
               status_checked++;
               compare_field("mop_close_coil",
                             PRE_RELAYS'(rsp_ch.mop_close_coil),
                             PRE_RELAYS'(want_status.mop_close_coil));
               compare_field("mop_open_coil",
                             PRE_RELAYS'(rsp_ch.mop_open_coil),
                             PRE_RELAYS'(want_status.mop_open_coil));
               compare_field("vcb_close_coil",
                             PRE_RELAYS'(rsp_ch.vcb_close_coil),
                             PRE_RELAYS'(want_status.vcb_close_coil));
               compare_field("vcb_open_coil",
                             PRE_RELAYS'(rsp_ch.vcb_open_coil),
                             PRE_RELAYS'(want_status.vcb_open_coil));
               compare_field("precharge_relays", rsp_ch.precharge_relays,
                             want_status.precharge_relays);
               compare_field("dc_main_relay",
                             PRE_RELAYS'(rsp_ch.dc_main_relay),
                             PRE_RELAYS'(want_status.dc_main_relay));
               compare_field("dc_pair_relays",
                             PRE_RELAYS'(rsp_ch.dc_pair_relays),
                             PRE_RELAYS'(want_status.dc_pair_relays));
               compare_field("mop_busy",
                             PRE_RELAYS'(rsp_ch.mop_busy),
                             PRE_RELAYS'(want_status.mop_busy));
               compare_field("vcb_busy",
                             PRE_RELAYS'(rsp_ch.vcb_busy),
                             PRE_RELAYS'(want_status.vcb_busy));
               compare_field("precharge_busy",
                             PRE_RELAYS'(rsp_ch.precharge_busy),
                             PRE_RELAYS'(want_status.precharge_busy));
            end
         end
      end
   end

   initial begin
      logic [CMD_WIDTH-1:0] word;
      logic                 mfb, vfb;
      int                   n_ticks;

      clock               = 1'b0;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.func         = FUNC_TICK;
      req_ch.command_map  = '0;
      req_ch.mop_feedback = 1'b0;
      req_ch.vcb_feedback = 1'b0;
      rsp_ch.ready        = 1'b0;

      // directed part
      add_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);   // tick while all idle
      add_item(FUNC_CMD,  16'h0000, 1'b0, 1'b0);
      add_item(FUNC_CMD,  16'h0001, 1'b0, 1'b0);   // close refused, breaker reads open
      add_item(FUNC_CMD,  16'h0002, 1'b1, 1'b1);   // open refused, breaker reads closed
      add_item(FUNC_CMD,  16'hFFFF, 1'b1, 1'b1);   // every bit: lower trigger of each pair wins
      add_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      add_item(FUNC_CMD,  16'h003A, 1'b0, 1'b0);   // open both breakers; pre-charge on wins over off
      add_item(FUNC_CMD,  16'h00C1, 1'b1, 1'b1);   // close while busy is dropped
      add_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      add_item(FUNC_CMD,  16'h0040, 1'b0, 1'b0);
      add_item(FUNC_CMD,  16'h0080, 1'b0, 1'b0);
      add_item(FUNC_CMD,  16'hFF00, 1'b1, 1'b1);   // upper bits do nothing, DC relays drop
      add_item(FUNC_CMD,  16'h0030, 1'b0, 1'b0);   // both pre-charge bits: on wins
      add_item(FUNC_TICK, 16'hFFFF, 1'b1, 1'b1);   // tick ignores word and feedback
      add_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      add_item(FUNC_CMD,  16'h000C, 1'b0, 1'b0);   // vcb: close refused, open taken
      add_item(FUNC_CMD,  16'h0003, 1'b1, 1'b1);   // mop close taken
      add_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);
      add_item(FUNC_TICK, 16'h0000, 1'b0, 1'b0);

      // random part: mostly a command followed by ticks, some noise
      while (pending_requests.size() < 1225) begin
         if ($urandom_range(0, 9) == 0) begin
            add_item(1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
         end else begin
            word = 16'($urandom);
            if ($urandom_range(0, 1) == 0)
               word[5:0] = 6'(1 << $urandom_range(0, 5));
            mfb = 1'($urandom);
            vfb = 1'($urandom);
            // usually hand the feedback that lets the requested trigger through
            if ($urandom_range(0, 9) < 7) begin
               if (word[CMD_MOP_CLOSE])     mfb = 1'b1;
               else if (word[CMD_MOP_OPEN]) mfb = 1'b0;
               if (word[CMD_VCB_CLOSE])     vfb = 1'b1;
               else if (word[CMD_VCB_OPEN]) vfb = 1'b0;
            end
            add_item(FUNC_CMD, word, mfb, vfb);
            n_ticks = $urandom_range(0, 4);
            repeat (n_ticks)
               add_item(FUNC_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_ch.valid || expected_status.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Checked %0d result items from %0d commands and %0d ticks.",
               status_checked, command_count, tick_count);
      $display("Sequencer triggers taken: %0d, mismatches: %0d.",
               triggers_taken, mismatch_count);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
